### sv/assert_macros.svh
// Assertion macros used by the RTL in auto_exposure_adaptation.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AEA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define AEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### sv/aea_pkg.sv
// Constants, widths and the exp2 root table for the auto exposure block.
`timescale 1ns / 1ps
`default_nettype none

package aea_pkg;

    localparam int FRAC_BITS      = 12;
    localparam int MAX_STOPS_DOWN = 20;
    localparam int ONE            = 1 << FRAC_BITS;

    localparam int LOG_W     = 19;
    localparam int GAIN_W    = 18;
    localparam int LIN_W     = 24;
    localparam int RATE_W    = 17;
    localparam int RATE_FRAC = 16;
    localparam int CFG_W     = 19;
    localparam int CFG_IDX_W = 3;

    // exp2 accumulator: Q1.30 in 31 bits
    localparam int M_FRAC    = 30;
    localparam int M_W       = 31;
    localparam int PROD_W    = 62;
    localparam int LIN_SHIFT = M_FRAC - (LIN_W - 1);
    localparam int SHIFT_MAX = LIN_SHIFT + MAX_STOPS_DOWN;
    localparam int SHW       = $clog2(SHIFT_MAX + 1);
    localparam int JW        = $clog2(FRAC_BITS);

    // largest |level - target| that snaps: 100 * diff < ONE
    localparam int SNAP_MAX  = (ONE - 1) / 100;

    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1 << RATE_FRAC);
    localparam logic [LIN_W-1:0]  LIN_ONE  = LIN_W'(1 << (LIN_W - 1));

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOG2    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LOG2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEIL_LOG2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_BRIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DARK   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_LOG2 = 3'd6;

    localparam logic signed [LOG_W-1:0] KEY_RESET   = -19'sd10133;
    localparam logic signed [LOG_W-1:0] FLOOR_RESET = -19'sd122880;
    localparam logic signed [LOG_W-1:0] CEIL_RESET  = 19'sd98304;
    localparam logic [RATE_W-1:0]       RATE_RESET  = 17'd2621;

    typedef logic [31:0] vtab_t [FRAC_BITS];

    function automatic logic [31:0] isqrt64(input logic [63:0] x);
        logic [31:0] res;
        logic [31:0] trial;
        res = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = res | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= x) begin
                res = trial;
            end
        end
        return res;
    endfunction

    // entry k is 2^(2^-(k+1)) in Q2.30, each the root of the one before
    function automatic vtab_t build_vtab();
        vtab_t       t;
        logic [63:0] prev;
        prev = 64'd1 << 31;
        for (int j = 0; j < FRAC_BITS; j++) begin
            t[j] = isqrt64(prev << M_FRAC);
            prev = 64'(t[j]);
        end
        return t;
    endfunction

    localparam vtab_t VTAB = build_vtab();

endpackage

`default_nettype wire

### sv/auto_exposure_adaptation.sv
// Auto exposure eye adaptation: blend, gain and linear gain on one shared multiplier.
// A request steps through CLAMP, BLEND_MUL and BLEND_FIN when a blend runs, GAIN, then EXP
// over the fraction bits of gain_log2 (EXP_RND adds one multiply for each set bit), SCALE
// and DONE, which registers the result. A new request is taken only in ST_IDLE.
// A new request is taken while the previous result waits on m_ready.
// aresetn (synchronous, active low) restores register defaults and clears the level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module auto_exposure_adaptation (
    input  wire                                aclk,
    input  wire                                aresetn,

    input  wire                                cfg_wr_en,
    input  wire [aea_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [aea_pkg::CFG_W-1:0]           cfg_wdata,

    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire                                s_command,
    input  wire signed [aea_pkg::LOG_W-1:0]    s_measured_log2,
    input  wire                                s_measured_finite,

    output logic                               m_valid,
    input  wire                                m_ready,
    output logic                               m_accepted,
    output logic signed [aea_pkg::LOG_W-1:0]   m_target_log2,
    output logic signed [aea_pkg::LOG_W-1:0]   m_adapted_log2,
    output logic                               m_adapted_ok,
    output logic signed [aea_pkg::GAIN_W-1:0]  m_gain_log2,
    output logic [aea_pkg::LIN_W-1:0]          m_gain_linear,
    output logic signed [aea_pkg::LOG_W-1:0]   m_pre_exposure_log2
);

    localparam int LOG_W  = aea_pkg::LOG_W;
    localparam int GAIN_W = aea_pkg::GAIN_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_BLEND_MUL,
        ST_BLEND_FIN,
        ST_GAIN,
        ST_EXP,
        ST_EXP_RND,
        ST_SCALE,
        ST_DONE
    } state_t;

    // configuration registers
    logic                              auto_enable_reg;
    logic signed [LOG_W-1:0]           key_reg;
    logic signed [LOG_W-1:0]           floor_reg;
    logic signed [LOG_W-1:0]           ceil_reg;
    logic [aea_pkg::RATE_W-1:0]        rate_bright_reg;
    logic [aea_pkg::RATE_W-1:0]        rate_dark_reg;
    logic signed [LOG_W-1:0]           cam_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_enable_reg <= 1'b1;
            key_reg         <= aea_pkg::KEY_RESET;
            floor_reg       <= aea_pkg::FLOOR_RESET;
            ceil_reg        <= aea_pkg::CEIL_RESET;
            rate_bright_reg <= aea_pkg::RATE_RESET;
            rate_dark_reg   <= aea_pkg::RATE_RESET;
            cam_reg         <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                aea_pkg::CFG_AUTO_ENABLE: auto_enable_reg <= cfg_wdata[0];
                aea_pkg::CFG_KEY_LOG2:    key_reg         <= $signed(cfg_wdata[LOG_W-1:0]);
                aea_pkg::CFG_FLOOR_LOG2:  floor_reg       <= $signed(cfg_wdata[LOG_W-1:0]);
                aea_pkg::CFG_CEIL_LOG2:   ceil_reg        <= $signed(cfg_wdata[LOG_W-1:0]);
                aea_pkg::CFG_RATE_BRIGHT: rate_bright_reg <= cfg_wdata[aea_pkg::RATE_W-1:0];
                aea_pkg::CFG_RATE_DARK:   rate_dark_reg   <= cfg_wdata[aea_pkg::RATE_W-1:0];
                aea_pkg::CFG_CAMERA_LOG2: cam_reg         <= $signed(cfg_wdata[LOG_W-1:0]);
                default: ;
            endcase
        end
    end

    // sequencer state and working registers
    state_t                            state_reg, state_next;
    logic                              cmd_reg, cmd_next;
    logic                              fin_reg, fin_next;
    logic signed [LOG_W-1:0]           meas_reg, meas_next;
    logic signed [LOG_W-1:0]           level_reg, level_next;
    logic                              held_reg, held_next;
    logic signed [LOG_W-1:0]           target_reg, target_next;
    logic                              acc_reg, acc_next;
    logic                              neg_reg, neg_next;
    logic [aea_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic signed [GAIN_W-1:0]          gain_reg, gain_next;
    logic [aea_pkg::FRAC_BITS-1:0]     frac_reg, frac_next;
    logic [aea_pkg::SHW-1:0]           shift_reg, shift_next;
    logic [aea_pkg::M_W-1:0]           m_reg, m_next;
    logic [aea_pkg::JW-1:0]            k_reg, k_next;
    logic signed [LOG_W-1:0]           pre_reg, pre_next;
    logic [aea_pkg::LIN_W-1:0]         lin_reg, lin_next;

    // result registers
    logic                              out_valid_reg, out_valid_next;
    logic                              out_acc_reg, out_acc_next;
    logic signed [LOG_W-1:0]           out_target_reg, out_target_next;
    logic signed [LOG_W-1:0]           out_level_reg, out_level_next;
    logic                              out_held_reg, out_held_next;
    logic signed [GAIN_W-1:0]          out_gain_reg, out_gain_next;
    logic [aea_pkg::LIN_W-1:0]         out_lin_reg, out_lin_next;
    logic signed [LOG_W-1:0]           out_pre_reg, out_pre_next;

    // shared multiplier
    logic [31:0]                       mul_a, mul_b;
    logic [63:0]                       mul_p;

    // datapath terms
    logic signed [LOG_W-1:0]           clamp_lo, clamp_t;
    logic signed [LOG_W:0]             d_val;
    logic [LOG_W:0]                    d_mag;
    logic [aea_pkg::RATE_W-1:0]        rate_sel, rate_eff;
    logic [LOG_W:0]                    q_mag;
    logic signed [LOG_W+1:0]           delta, a_wide, diff_s;
    logic [LOG_W+1:0]                  diff_mag;
    logic signed [LOG_W:0]             kd;
    logic signed [GAIN_W-1:0]          g_val, g_int;
    logic signed [LOG_W:0]             pre_sum;
    logic [aea_pkg::JW-1:0]            bit_idx;
    logic                              k_last;
    logic [63:0]                       round_sum;

    assign mul_p = mul_a * mul_b;

    always_comb begin
        clamp_lo = (meas_reg < floor_reg) ? floor_reg : meas_reg;
        clamp_t  = (clamp_lo > ceil_reg) ? ceil_reg : clamp_lo;

        d_val    = {target_reg[LOG_W-1], target_reg} - {level_reg[LOG_W-1], level_reg};
        d_mag    = d_val[LOG_W] ? (LOG_W+1)'(-d_val) : d_val;
        rate_sel = (target_reg > level_reg) ? rate_bright_reg : rate_dark_reg;
        rate_eff = (rate_sel > aea_pkg::RATE_ONE) ? aea_pkg::RATE_ONE : rate_sel;

        q_mag    = (LOG_W+1)'((prod_reg + aea_pkg::PROD_W'(1 << (aea_pkg::RATE_FRAC - 1)))
                              >> aea_pkg::RATE_FRAC);
        delta    = neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        a_wide   = {{2{level_reg[LOG_W-1]}}, level_reg} + delta;
        diff_s   = a_wide - {{2{target_reg[LOG_W-1]}}, target_reg};
        diff_mag = diff_s[LOG_W+1] ? (LOG_W+2)'(-diff_s) : diff_s;

        kd = {key_reg[LOG_W-1], key_reg} - {level_reg[LOG_W-1], level_reg};
        if (!(auto_enable_reg && held_reg)) begin
            g_val = '0;
        end else if (kd > 0) begin
            g_val = '0;
        end else if (kd < -(LOG_W+1)'(aea_pkg::MAX_STOPS_DOWN * aea_pkg::ONE)) begin
            g_val = -GAIN_W'(aea_pkg::MAX_STOPS_DOWN * aea_pkg::ONE);
        end else begin
            g_val = kd[GAIN_W-1:0];
        end
        g_int   = g_val >>> aea_pkg::FRAC_BITS;
        pre_sum = {cam_reg[LOG_W-1], cam_reg} + (LOG_W+1)'(g_val);

        bit_idx   = aea_pkg::JW'(aea_pkg::FRAC_BITS - 1) - k_reg;
        k_last    = (k_reg == aea_pkg::JW'(aea_pkg::FRAC_BITS - 1));
        round_sum = 64'(m_reg) + (64'd1 << (shift_reg - aea_pkg::SHW'(1)));

        if (state_reg == ST_BLEND_MUL) begin
            mul_a = 32'(d_mag);
            mul_b = 32'(rate_eff);
        end else begin
            mul_a = 32'(m_reg);
            mul_b = aea_pkg::VTAB[k_reg];
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        fin_next        = fin_reg;
        meas_next       = meas_reg;
        level_next      = level_reg;
        held_next       = held_reg;
        target_next     = target_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        gain_next       = gain_reg;
        frac_next       = frac_reg;
        shift_next      = shift_reg;
        m_next          = m_reg;
        k_next          = k_reg;
        pre_next        = pre_reg;
        lin_next        = lin_reg;
        out_valid_next  = out_valid_reg;
        out_acc_next    = out_acc_reg;
        out_target_next = out_target_reg;
        out_level_next  = out_level_reg;
        out_held_next   = out_held_reg;
        out_gain_next   = out_gain_reg;
        out_lin_next    = out_lin_reg;
        out_pre_next    = out_pre_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_command;
                    fin_next   = s_measured_finite;
                    meas_next  = s_measured_log2;
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                state_next  = ST_GAIN;
                target_next = '0;
                acc_next    = 1'b0;
                if (cmd_reg) begin
                    level_next = '0;
                    held_next  = 1'b0;
                end else if (fin_reg) begin
                    target_next = clamp_t;
                    acc_next    = 1'b1;
                    if (held_reg) begin
                        state_next = ST_BLEND_MUL;
                    end else begin
                        level_next = clamp_t;
                        held_next  = 1'b1;
                    end
                end
            end
            ST_BLEND_MUL: begin
                prod_next  = mul_p[aea_pkg::PROD_W-1:0];
                neg_next   = d_val[LOG_W];
                state_next = ST_BLEND_FIN;
            end
            ST_BLEND_FIN: begin
                if (diff_mag <= (LOG_W+2)'(aea_pkg::SNAP_MAX)) begin
                    level_next = target_reg;
                end else begin
                    level_next = a_wide[LOG_W-1:0];
                end
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                gain_next  = g_val;
                frac_next  = g_val[aea_pkg::FRAC_BITS-1:0];
                shift_next = aea_pkg::SHW'(aea_pkg::LIN_SHIFT) + aea_pkg::SHW'(-g_int);
                m_next     = aea_pkg::M_W'(1 << aea_pkg::M_FRAC);
                k_next     = '0;
                if (pre_sum > (LOG_W+1)'((1 << (LOG_W - 1)) - 1)) begin
                    pre_next = LOG_W'((1 << (LOG_W - 1)) - 1);
                end else if (pre_sum < -(LOG_W+1)'(1 << (LOG_W - 1))) begin
                    pre_next = -LOG_W'(1 << (LOG_W - 1));
                end else begin
                    pre_next = pre_sum[LOG_W-1:0];
                end
                state_next = ST_EXP;
            end
            ST_EXP: begin
                if (frac_reg[bit_idx]) begin
                    prod_next  = mul_p[aea_pkg::PROD_W-1:0];
                    state_next = ST_EXP_RND;
                end else if (k_last) begin
                    state_next = ST_SCALE;
                end else begin
                    k_next = k_reg + aea_pkg::JW'(1);
                end
            end
            ST_EXP_RND: begin
                m_next = aea_pkg::M_W'((prod_reg + (aea_pkg::PROD_W'(1) << (aea_pkg::M_FRAC - 1)))
                                       >> aea_pkg::M_FRAC);
                if (k_last) begin
                    state_next = ST_SCALE;
                end else begin
                    k_next     = k_reg + aea_pkg::JW'(1);
                    state_next = ST_EXP;
                end
            end
            ST_SCALE: begin
                lin_next   = aea_pkg::LIN_W'(round_sum >> shift_reg);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_acc_next    = acc_reg;
                    out_target_next = target_reg;
                    out_level_next  = level_reg;
                    out_held_next   = held_reg;
                    out_gain_next   = gain_reg;
                    out_lin_next    = lin_reg;
                    out_pre_next    = pre_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_next_assign: begin
            cmd_reg        <= cmd_next;
            fin_reg        <= fin_next;
            meas_reg       <= meas_next;
            target_reg     <= target_next;
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            prod_reg       <= prod_next;
            gain_reg       <= gain_next;
            frac_reg       <= frac_next;
            shift_reg      <= shift_next;
            m_reg          <= m_next;
            k_reg          <= k_next;
            pre_reg        <= pre_next;
            lin_reg        <= lin_next;
            out_acc_reg    <= out_acc_next;
            out_target_reg <= out_target_next;
            out_level_reg  <= out_level_next;
            out_held_reg   <= out_held_next;
            out_gain_reg   <= out_gain_next;
            out_lin_reg    <= out_lin_next;
            out_pre_reg    <= out_pre_next;
        end
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            level_reg     <= '0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = out_valid_reg;
    assign m_accepted          = out_acc_reg;
    assign m_target_log2       = out_target_reg;
    assign m_adapted_log2      = out_level_reg;
    assign m_adapted_ok        = out_held_reg;
    assign m_gain_log2         = out_gain_reg;
    assign m_gain_linear       = out_lin_reg;
    assign m_pre_exposure_log2 = out_pre_reg;

    `AEA_ASSERT_IMPL(a_unity_gain, aclk, aresetn, m_valid && (m_gain_log2 == '0), m_gain_linear == aea_pkg::LIN_ONE)
    `AEA_ASSERT_IMPL(a_no_level_no_gain, aclk, aresetn, m_valid && !m_adapted_ok, m_gain_log2 == '0)
    `AEA_ASSERT_IMPL(a_accept_holds_level, aclk, aresetn, m_valid && m_accepted, m_adapted_ok)
    `AEA_ASSERT_NEXT(a_busy_after_request, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

`default_nettype wire

### sim/tb.sv
// Testbench for auto_exposure_adaptation: directed table, then random frames checked by a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int LOG_W          = aea_pkg::LOG_W;
    localparam int GAIN_W         = aea_pkg::GAIN_W;
    localparam int LIN_W          = aea_pkg::LIN_W;
    localparam int RATE_W         = aea_pkg::RATE_W;
    localparam int CFG_W          = aea_pkg::CFG_W;
    localparam int CFG_IDX_W      = aea_pkg::CFG_IDX_W;
    localparam int FRAC_BITS      = aea_pkg::FRAC_BITS;
    localparam int ONE            = aea_pkg::ONE;
    localparam int MAX_STOPS_DOWN = aea_pkg::MAX_STOPS_DOWN;

    localparam int STALL_LIMIT = 4000;
    localparam int FRAMES      = 900;

    typedef enum logic {CMD_SUBMIT = 1'b0, CMD_RESET = 1'b1} cmd_t;
    typedef enum logic {ROW_FRAME, ROW_REG} row_kind_t;

    typedef struct packed {
        logic                     accepted;
        logic signed [LOG_W-1:0]  target;
        logic signed [LOG_W-1:0]  adapted;
        logic                     adapted_ok;
        logic signed [GAIN_W-1:0] gain;
        logic [LIN_W-1:0]         lin;
        logic signed [LOG_W-1:0]  pre;
    } frame_report_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_W-1:0]        data;
        cmd_t                    cmd;
        logic signed [LOG_W-1:0] meas;
        logic                    fin;
        logic                    typed;
        frame_report_t           want;
    } row_t;

    localparam frame_report_t IDLE_REPORT = '{accepted: 1'b0, target: '0, adapted: '0,
        adapted_ok: 1'b0, gain: '0, lin: aea_pkg::LIN_ONE, pre: '0};

    logic                    aclk              = 1'b0;
    logic                    aresetn           = 1'b0;
    logic                    cfg_wr_en         = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index         = '0;
    logic [CFG_W-1:0]        cfg_wdata         = '0;
    logic                    s_valid           = 1'b0;
    logic                    s_ready;
    logic                    s_command         = 1'b0;
    logic signed [LOG_W-1:0] s_measured_log2   = '0;
    logic                    s_measured_finite = 1'b0;
    logic                    m_valid;
    logic                    m_ready           = 1'b0;
    logic                    m_accepted;
    logic signed [LOG_W-1:0] m_target_log2;
    logic signed [LOG_W-1:0] m_adapted_log2;
    logic                    m_adapted_ok;
    logic signed [GAIN_W-1:0] m_gain_log2;
    logic [LIN_W-1:0]        m_gain_linear;
    logic signed [LOG_W-1:0] m_pre_exposure_log2;

    // predictor state and register copies
    logic                    reg_auto      = 1'b1;
    logic signed [LOG_W-1:0] reg_key       = aea_pkg::KEY_RESET;
    logic signed [LOG_W-1:0] reg_floor     = aea_pkg::FLOOR_RESET;
    logic signed [LOG_W-1:0] reg_ceil      = aea_pkg::CEIL_RESET;
    logic [RATE_W-1:0]       reg_rate_up   = aea_pkg::RATE_RESET;
    logic [RATE_W-1:0]       reg_rate_down = aea_pkg::RATE_RESET;
    logic signed [LOG_W-1:0] reg_cam       = '0;
    logic signed [LOG_W-1:0] adapt_level   = '0;
    logic                    level_held    = 1'b0;
    longint                  root_tab [0:FRAC_BITS];

    frame_report_t report_q [$];
    row_t          dir_tab [$];
    int            err_cnt      = 0;
    int            stall_cycles = 0;
    logic          quiet        = 1'b0;

    auto_exposure_adaptation i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_measured_log2    (s_measured_log2),
        .s_measured_finite  (s_measured_finite),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_accepted         (m_accepted),
        .m_target_log2      (m_target_log2),
        .m_adapted_log2     (m_adapted_log2),
        .m_adapted_ok       (m_adapted_ok),
        .m_gain_log2        (m_gain_log2),
        .m_gain_linear      (m_gain_linear),
        .m_pre_exposure_log2(m_pre_exposure_log2)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic frame_report_t adapt_step(input cmd_t cmd,
                                                 input logic signed [LOG_W-1:0] meas,
                                                 input logic fin);
        frame_report_t r;
        longint t, prv, d, mag, q, a, diff, rate, g, pre, n, ip, fr, m, sh;
        int j;
        r = '0;
        if (cmd == CMD_RESET) begin
            adapt_level = '0;
            level_held  = 1'b0;
        end else if (fin) begin
            t = meas;
            if (t < longint'(reg_floor)) t = reg_floor;
            if (t > longint'(reg_ceil)) t = reg_ceil;
            a = t;
            if (level_held) begin
                prv  = adapt_level;
                d    = t - prv;
                rate = (t > prv) ? longint'(reg_rate_up) : longint'(reg_rate_down);
                if (rate > 65536) rate = 65536;
                mag  = (d < 0) ? -d : d;
                q    = (mag * rate + 32768) >>> 16;
                a    = prv + ((d < 0) ? -q : q);
                diff = a - t;
                if (diff < 0) diff = -diff;
                // within 0.01 stop: snap
                if (100 * diff < ONE) a = t;
            end
            adapt_level = LOG_W'(a);
            level_held  = 1'b1;
            r.accepted  = 1'b1;
            r.target    = LOG_W'(t);
        end
        g = 0;
        if (reg_auto && level_held) begin
            g = longint'(reg_key) - longint'(adapt_level);
            if (g > 0) g = 0;
            if (g < -MAX_STOPS_DOWN * ONE) g = -MAX_STOPS_DOWN * ONE;
        end
        pre = longint'(reg_cam) + g;
        if (pre > 262143) pre = 262143;
        if (pre < -262144) pre = -262144;
        // exp2 of the gain: integer stops shift, fraction bits multiply roots
        m  = longint'(1) <<< 30;
        ip = 0;
        fr = 0;
        if (g < 0) begin
            n  = -g;
            ip = -((n + ONE - 1) / ONE);
            fr = (-ip) * ONE - n;
        end
        for (j = 1; j <= FRAC_BITS; j++) begin
            if (fr[FRAC_BITS - j]) m = (m * root_tab[j] + (longint'(1) <<< 29)) >>> 30;
        end
        sh           = 7 - ip;
        r.adapted    = adapt_level;
        r.adapted_ok = level_held;
        r.gain       = GAIN_W'(g);
        r.lin        = LIN_W'((m + (longint'(1) <<< (sh - 1))) >>> sh);
        r.pre        = LOG_W'(pre);
        return r;
    endfunction

    function automatic string fmt_report(input frame_report_t r);
        return $sformatf("acc=%0d tgt=%0d lvl=%0d ok=%0d gain=%0d lin=%0d pre=%0d",
            r.accepted, r.target, r.adapted, r.adapted_ok, r.gain, r.lin, r.pre);
    endfunction

    function automatic row_t frame_row(input cmd_t cmd, input int meas, input logic fin);
        row_t r;
        r      = '0;
        r.kind = ROW_FRAME;
        r.cmd  = cmd;
        r.meas = LOG_W'(meas);
        r.fin  = fin;
        return r;
    endfunction

    function automatic row_t known_row(input cmd_t cmd, input int meas, input logic fin,
                                       input frame_report_t want);
        row_t r;
        r       = frame_row(cmd, meas, fin);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
        row_t r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.data = CFG_W'(data);
        return r;
    endfunction

    task automatic push_frame(input row_t row);
        int            gap;
        frame_report_t res;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_command         <= row.cmd;
        s_measured_log2   <= row.meas;
        s_measured_finite <= row.fin;
        do @(posedge aclk); while (!s_ready);
        res = adapt_step(row.cmd, row.meas, row.fin);
        if (row.typed) res = row.want;
        report_q.push_back(res);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        logic [CFG_W-1:0] w;
        w = CFG_W'(data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= w;
        case (idx)
            aea_pkg::CFG_AUTO_ENABLE: reg_auto      = w[0];
            aea_pkg::CFG_KEY_LOG2:    reg_key       = w;
            aea_pkg::CFG_FLOOR_LOG2:  reg_floor     = w;
            aea_pkg::CFG_CEIL_LOG2:   reg_ceil      = w;
            aea_pkg::CFG_RATE_BRIGHT: reg_rate_up   = w[RATE_W-1:0];
            aea_pkg::CFG_RATE_DARK:   reg_rate_down = w[RATE_W-1:0];
            aea_pkg::CFG_CAMERA_LOG2: reg_cam       = w;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // result side: random back-pressure, in-order compare
    always @(posedge aclk) begin : result_side
        frame_report_t got;
        frame_report_t want;
        int            hold;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold = 0;
        end else if (m_valid && m_ready) begin
            got.accepted   = m_accepted;
            got.target     = m_target_log2;
            got.adapted    = m_adapted_log2;
            got.adapted_ok = m_adapted_ok;
            got.gain       = m_gain_log2;
            got.lin        = m_gain_linear;
            got.pre        = m_pre_exposure_log2;
            if (report_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected result: %s", fmt_report(got));
            end else begin
                want = report_q.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("mismatch at %0t", $time);
                        $display("  exp %s", fmt_report(want));
                        $display("  got %s", fmt_report(got));
                    end
                end
            end
            hold = quiet ? 0 : $urandom_range(0, 18);
            m_ready <= (hold == 0);
        end else if (hold > 1) begin
            hold--;
            m_ready <= 1'b0;
        end else begin
            hold = 0;
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        longint unsigned x, r, b;
        int              live, n, k, lo, hi, scene, meas;
        cmd_t            cmd;
        logic            fin;

        // roots 2^(2^-j) in Q2.30, each the floor sqrt of the previous one
        root_tab[0] = longint'(1) <<< 31;
        for (int j = 1; j <= FRAC_BITS; j++) begin
            x = longint'(root_tab[j-1]) << 30;
            r = 0;
            for (b = 64'd1 << 31; b != 0; b = b >> 1) begin
                if ((r + b) * (r + b) <= x) r = r + b;
            end
            root_tab[j] = longint'(r);
        end

        dir_tab.push_back(known_row(CMD_RESET, 0, 1'b1, IDLE_REPORT));
        dir_tab.push_back(known_row(CMD_SUBMIT, 1234, 1'b0, IDLE_REPORT));
        dir_tab.push_back(frame_row(CMD_SUBMIT, 0, 1'b1));
        dir_tab.push_back(frame_row(CMD_SUBMIT, 262143, 1'b1));
        dir_tab.push_back(frame_row(CMD_SUBMIT, -262144, 1'b1));
        dir_tab.push_back(frame_row(CMD_SUBMIT, -262144, 1'b0));
        dir_tab.push_back(known_row(CMD_RESET, 5000, 1'b1, IDLE_REPORT));
        dir_tab.push_back(reg_row(aea_pkg::CFG_AUTO_ENABLE, 0));
        dir_tab.push_back(known_row(CMD_SUBMIT, 20480, 1'b1, frame_report_t'{accepted: 1'b1,
            target: 19'sd20480, adapted: 19'sd20480, adapted_ok: 1'b1, gain: '0,
            lin: aea_pkg::LIN_ONE, pre: '0}));
        dir_tab.push_back(frame_row(CMD_SUBMIT, -4096, 1'b1));
        dir_tab.push_back(reg_row(aea_pkg::CFG_AUTO_ENABLE, 1));
        dir_tab.push_back(reg_row(aea_pkg::CFG_RATE_BRIGHT, 65536));
        dir_tab.push_back(reg_row(aea_pkg::CFG_RATE_DARK, 0));
        dir_tab.push_back(frame_row(CMD_SUBMIT, 40960, 1'b1));
        dir_tab.push_back(frame_row(CMD_SUBMIT, 36864, 1'b1));
        dir_tab.push_back(frame_row(CMD_SUBMIT, 40930, 1'b1));
        dir_tab.push_back(reg_row(aea_pkg::CFG_RATE_BRIGHT, 131071));
        dir_tab.push_back(frame_row(CMD_SUBMIT, 81920, 1'b1));
        dir_tab.push_back(reg_row(aea_pkg::CFG_KEY_LOG2, -262144));
        dir_tab.push_back(frame_row(CMD_SUBMIT, 81920, 1'b1));
        dir_tab.push_back(reg_row(aea_pkg::CFG_KEY_LOG2, 262143));
        dir_tab.push_back(frame_row(CMD_SUBMIT, 81000, 1'b1));
        dir_tab.push_back(reg_row(aea_pkg::CFG_KEY_LOG2, int'(aea_pkg::KEY_RESET)));
        dir_tab.push_back(reg_row(aea_pkg::CFG_CAMERA_LOG2, -262144));
        dir_tab.push_back(frame_row(CMD_SUBMIT, 12345, 1'b1));
        dir_tab.push_back(reg_row(aea_pkg::CFG_CAMERA_LOG2, 262143));
        dir_tab.push_back(frame_row(CMD_SUBMIT, -12345, 1'b1));
        // floor above ceiling: ceiling wins
        dir_tab.push_back(reg_row(aea_pkg::CFG_FLOOR_LOG2, 50000));
        dir_tab.push_back(reg_row(aea_pkg::CFG_CEIL_LOG2, -50000));
        dir_tab.push_back(reg_row(aea_pkg::CFG_RATE_DARK, 65536));
        dir_tab.push_back(frame_row(CMD_SUBMIT, 0, 1'b1));
        dir_tab.push_back(frame_row(CMD_SUBMIT, 262143, 1'b1));
        dir_tab.push_back(reg_row(aea_pkg::CFG_FLOOR_LOG2, -262144));
        dir_tab.push_back(reg_row(aea_pkg::CFG_CEIL_LOG2, 262143));
        dir_tab.push_back(reg_row(aea_pkg::CFG_RATE_BRIGHT, 30000));
        dir_tab.push_back(reg_row(aea_pkg::CFG_CAMERA_LOG2, 0));
        dir_tab.push_back(frame_row(CMD_SUBMIT, 262143, 1'b1));
        dir_tab.push_back(frame_row(CMD_SUBMIT, -262144, 1'b1));
        dir_tab.push_back(frame_row(CMD_SUBMIT, -7777, 1'b1));
        dir_tab.push_back(known_row(CMD_RESET, -1, 1'b0, IDLE_REPORT));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        quiet = $urandom_range(0, 1);
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_REG) begin
                drain();
                write_reg(dir_tab[i].idx, int'(dir_tab[i].data));
            end else begin
                push_frame(dir_tab[i]);
            end
        end

        live  = 0;
        scene = 0;
        while (live < FRAMES) begin
            drain();
            k = $urandom_range(0, 7);
            if (k == 0) begin
                lo = $urandom_range(0, 100000);
                hi = lo - int'($urandom_range(1, 100000));
            end else if (k == 1) begin
                lo = -262144;
                hi = 262143;
            end else begin
                lo = -int'($urandom_range(20000, 200000));
                hi = $urandom_range(20000, 200000);
            end
            write_reg(aea_pkg::CFG_AUTO_ENABLE, ($urandom_range(0, 5) != 0) ? 1 : 0);
            k = $urandom_range(0, 3);
            write_reg(aea_pkg::CFG_KEY_LOG2, (k == 0) ? int'($urandom)
                : int'(aea_pkg::KEY_RESET) + int'($urandom_range(0, 40000)) - 20000);
            write_reg(aea_pkg::CFG_FLOOR_LOG2, lo);
            write_reg(aea_pkg::CFG_CEIL_LOG2, hi);
            for (int j = 0; j < 2; j++) begin
                k = $urandom_range(0, 5);
                n = (k == 0) ? 0 : (k == 1) ? 65536 : (k == 2) ? $urandom_range(65537, 131071)
                    : (k == 3) ? $urandom_range(0, 4096) : $urandom_range(4096, 65536);
                write_reg((j == 0) ? aea_pkg::CFG_RATE_BRIGHT : aea_pkg::CFG_RATE_DARK, n);
            end
            k = $urandom_range(0, 5);
            write_reg(aea_pkg::CFG_CAMERA_LOG2, (k == 0) ? -262144 : (k == 1) ? 262143
                : (k == 2) ? int'($urandom) : int'($urandom_range(0, 40000)) - 20000);

            quiet = ($urandom_range(0, 3) == 0);
            n = $urandom_range(40, 120);
            repeat (n) begin
                k   = $urandom_range(0, 99);
                cmd = CMD_SUBMIT;
                fin = 1'b1;
                if (k < 4) begin
                    cmd  = CMD_RESET;
                    fin  = $urandom_range(0, 1);
                    meas = $urandom;
                end else if (k < 10) begin
                    fin  = 1'b0;
                    meas = $urandom;
                end else begin
                    if ($urandom_range(0, 11) == 0)
                        scene = int'($urandom_range(0, 200000)) - 100000;
                    k = $urandom_range(0, 9);
                    if (k < 5)
                        meas = scene + int'($urandom_range(0, 64)) - 32;
                    else if (k < 8 && hi > lo)
                        meas = lo + int'($urandom_range(0, hi - lo));
                    else
                        meas = $urandom;
                end
                push_frame(frame_row(cmd, meas, fin));
                live++;
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        if (err_cnt == 0 && report_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/aea_pkg.sv
sv/auto_exposure_adaptation.sv
sim/tb.sv
